// ===== hw/rtl/sads_pkg.sv =====
`default_nettype none

package sads_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_POP    = 1'b1;
  localparam logic SEL_LOWER = 1'b0;
  localparam logic SEL_UPPER = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic accept;
    logic emit;
  } sads_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sads_ram.sv =====
`default_nettype none

module sads_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sads_dp.sv =====
`default_nettype none

module sads_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sads_pkg::sads_cmd_t         cmd,
  input  wire logic                        op,
  input  wire logic                        stack_sel,
  input  wire logic [sads_pkg::VALUE_W-1:0] value,
  output logic      [sads_pkg::STATUS_W-1:0] status,
  output logic      [sads_pkg::VALUE_W-1:0] popped,
  output logic                             is_full,
  output logic                             lower_empty,
  output logic                             upper_empty
);

  import sads_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   DEPTH_S = (CNT_W + 1)'(DEPTH);

  logic [CNT_W-1:0]      lower_count, lower_count_next;
  logic [CNT_W-1:0]      upper_count, upper_count_next;
  logic [CNT_W:0]        total;
  logic                  full_now;
  logic                  push_ok;
  logic                  pop_ok;
  logic [STATUS_W-1:0]   status_next;
  logic [CNT_W-1:0]      waddr_c, raddr_c;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [STATUS_W-1:0]   status_q;
  logic                  pop_q;

  assign total    = {1'b0, lower_count} + {1'b0, upper_count};
  assign full_now = (total == DEPTH_S);

  always_comb begin
    push_ok          = 1'b0;
    pop_ok           = 1'b0;
    status_next      = ST_DONE;
    lower_count_next = lower_count;
    upper_count_next = upper_count;
    waddr_c          = lower_count;
    raddr_c          = lower_count - 1'b1;
    if (stack_sel == SEL_UPPER) begin
      waddr_c = DEPTH_C - 1'b1 - upper_count;
      raddr_c = DEPTH_C - upper_count;
    end
    if (op == OP_PUSH) begin
      if (full_now) begin
        status_next = ST_FULL;
      end else begin
        push_ok = 1'b1;
        if (stack_sel == SEL_LOWER) begin
          lower_count_next = lower_count + 1'b1;
        end else begin
          upper_count_next = upper_count + 1'b1;
        end
      end
    end else begin
      if (stack_sel == SEL_LOWER) begin
        if (lower_count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          pop_ok           = 1'b1;
          lower_count_next = lower_count - 1'b1;
        end
      end else begin
        if (upper_count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          pop_ok           = 1'b1;
          upper_count_next = upper_count - 1'b1;
        end
      end
    end
  end

  sads_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept && push_ok),
    .waddr (waddr_c[ADDR_W-1:0]),
    .wdata (DATA_WIDTH'($signed(value))),
    .re    (cmd.accept && pop_ok),
    .raddr (raddr_c[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_count <= '0;
      upper_count <= '0;
    end else if (cmd.accept) begin
      lower_count <= lower_count_next;
      upper_count <= upper_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_q <= status_next;
      pop_q    <= pop_ok;
    end
    if (cmd.emit) begin
      status      <= status_q;
      popped      <= pop_q ? VALUE_W'($signed(rd_data)) : '0;
      is_full     <= full_now;
      lower_empty <= (lower_count == '0);
      upper_empty <= (upper_count == '0);
    end
  end

  // counts never exceed the shared store
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= DEPTH_S)
    else $error("stack counts exceed store depth");

  // refused push leaves both stacks alone
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && op == OP_PUSH && full_now |=>
      $stable(lower_count) && $stable(upper_count))
    else $error("refused push changed counts");

  // pop on an empty lower stack is refused
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && op == OP_POP && stack_sel == SEL_LOWER && lower_count == '0 |=>
      status_q == ST_EMPTY && $stable(lower_count))
    else $error("pop on empty lower stack not refused");

endmodule

`default_nettype wire

// ===== hw/rtl/sads_ctrl.sv =====
`default_nettype none

module sads_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sads_pkg::sads_cmd_t      cmd
);

  import sads_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign in_ready   = (state == S_IDLE) && (!out_valid || out_ready);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.emit   = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (cmd.accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.emit ##1 out_valid)
    else $error("accepted item did not produce a result");

  a_exec_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid)
    else $error("result overwritten before taken");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !in_ready)
    else $error("item accepted while another is in flight");

endmodule

`default_nettype wire

// ===== hw/rtl/shared_array_dual_stack.sv =====
// Each item is accepted in S_IDLE, where the store read is registered, then passes S_EXEC,
// which loads the output register from the store read port; one item is in flight at a time.
// The next item is accepted while a result waits, as long as it is taken that cycle.
// Reset (rst, synchronous, active high) empties both stacks; store contents are kept.
`default_nettype none

module shared_array_dual_stack (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value
  input  wire logic [1:0]  s_tuser,   // [0] op, [1] stack_sel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // [31:0] popped, [32] is_full, [33] lower_empty,
                                      // [34] upper_empty, [39:35] zero
  output logic      [1:0]  m_tuser    // [1:0] status
);

  import sads_pkg::*;

  sads_cmd_t             cmd;
  logic [VALUE_W-1:0]    popped;
  logic                  is_full;
  logic                  lower_empty;
  logic                  upper_empty;

  sads_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  sads_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (s_tuser[0]),
    .stack_sel   (s_tuser[1]),
    .value       (s_tdata),
    .status      (m_tuser),
    .popped      (popped),
    .is_full     (is_full),
    .lower_empty (lower_empty),
    .upper_empty (upper_empty)
  );

  assign m_tdata = {5'b0, upper_empty, lower_empty, is_full, popped};

endmodule

`default_nettype wire
